>>> src/ffca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg: shared types for the first-fit coalescing allocator
// Payload structs, result codes, cell commands and sequencer states.
// ----------------------------------------------------------------------------
package ffca_pkg;

   localparam int SIZE_W = 17;
   localparam int ADDR_W = 16;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_MEMORY  = 2'd1,
      STATUS_TABLE_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic              command;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_APPEND,
      OP_SET_USE,
      OP_CLR_USE,
      OP_SPLIT,
      OP_MERGE
   } op_type;

   typedef struct packed {
      logic fit;
      logic big;
      logic match;
   } cell_flag_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_INIT,
      ST_SEARCH,
      ST_TAKE,
      ST_FREE_FIND,
      ST_FREE_CLR,
      ST_FREE_NEXT,
      ST_FREE_PREV,
      ST_DONE
   } state_type;

endpackage

>>> src/ffca_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_cell: one entry of the address-ordered block table
// Holds start, length and in-use flag of one block and shifts with neighbors.
// ----------------------------------------------------------------------------
module ffca_cell #(
   parameter int DW           = 19,
   parameter int CW           = 7,
   parameter int IDX          = 0,
   parameter int HEADER_BYTES = 24,
   parameter int ALIGN_BYTES  = 8
) (
   input  logic                   clock,
   input  ffca_pkg::op_type       op,
   input  logic [CW-1:0]          op_pos,
   input  logic [CW-1:0]          count,
   input  logic [DW-1:0]          need,
   input  logic [15:0]            target,
   input  logic [DW-1:0]          app_start,
   input  logic [DW-1:0]          app_len,
   input  logic [DW-1:0]          prev_start,
   input  logic [DW-1:0]          prev_len,
   input  logic                   prev_use,
   input  logic [DW-1:0]          next_start,
   input  logic [DW-1:0]          next_len,
   input  logic                   next_use,
   output logic [DW-1:0]          start,
   output logic [DW-1:0]          len,
   output logic                   use_flag,
   output ffca_pkg::cell_flag_type flags
);

   localparam logic [CW-1:0] IDX_C = CW'(IDX);

   logic [DW-1:0] start_ff, start_in;
   logic [DW-1:0] len_ff, len_in;
   logic          use_ff, use_in;
   logic [CW-1:0] pos_next;
   logic          valid;

   assign pos_next = op_pos + CW'(1);

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      use_in   = use_ff;
      case (op)
         ffca_pkg::OP_APPEND: begin
            if (IDX_C == op_pos) begin
               start_in = app_start;
               len_in   = app_len;
               use_in   = 1'b0;
            end
         end
         ffca_pkg::OP_SET_USE: begin
            if (IDX_C == op_pos) use_in = 1'b1;
         end
         ffca_pkg::OP_CLR_USE: begin
            if (IDX_C == op_pos) use_in = 1'b0;
         end
         ffca_pkg::OP_SPLIT: begin
            if (IDX_C == op_pos) begin
               len_in = need;
               use_in = 1'b1;
            end else if (IDX_C == pos_next) begin
               start_in = prev_start + need;
               len_in   = prev_len - need;
               use_in   = 1'b0;
            end else if (IDX_C > pos_next) begin
               start_in = prev_start;
               len_in   = prev_len;
               use_in   = prev_use;
            end
         end
         ffca_pkg::OP_MERGE: begin
            if (IDX_C == op_pos) begin
               len_in = len_ff + next_len;
            end else if (IDX_C > op_pos) begin
               start_in = next_start;
               len_in   = next_len;
               use_in   = next_use;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
      use_ff   <= use_in;
   end

   assign valid       = IDX_C < count;
   assign flags.fit   = valid && !use_ff && (len_ff >= need);
   assign flags.big   = valid && !use_ff &&
                        (len_ff >= need + DW'(HEADER_BYTES) + DW'(ALIGN_BYTES));
   assign flags.match = valid && use_ff &&
                        (start_ff + DW'(HEADER_BYTES) == DW'(target));

   assign start    = start_ff;
   assign len      = len_ff;
   assign use_flag = use_ff;

endmodule

>>> src/first_fit_coalescing_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator: first-fit arena allocator with coalescing
// Request channel takes allocate or free commands; one response per request.
// ----------------------------------------------------------------------------
// Usage:
// The req channel (req_valid, req_stall, req_payload) carries one command per
// transfer. Every command gives exactly one transfer on the rsp channel with
// the allocated address and a status code. One command is worked on at a
// time; req_stall is high from acceptance until the result is written to the
// output register. An allocate rounds the size up by a reciprocal multiply,
// does the first fit setup, search and take, the last two again if the
// committed region grows. A free clears the matching used block, if any, and
// merges it with free neighbors. Both post the result, and the next command
// can be taken in the cycle after. The block table is a chain of MAX_BLOCKS
// cells that compare in parallel and shift one place to insert or remove an
// entry. A command that finishes while the output register is stalled holds
// until rsp_stall drops. The csr port sets the minimum growth chunk; the user
// must write it only while idle, not enforced by the block. Reset empties the
// table and the committed region and sets the chunk to 4096 bytes.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator #(
   parameter int ARENA_BYTES  = 65536,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 24,
   parameter int MAX_BLOCKS   = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffca_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffca_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [16:0]       csr_wr_data
);

   localparam int AB = $clog2(ARENA_BYTES + 1);
   localparam int DW = ((AB > ffca_pkg::SIZE_W) ? AB : ffca_pkg::SIZE_W) + 2;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int PW = $clog2(MAX_BLOCKS);
   localparam int XW = ffca_pkg::SIZE_W + 1;
   localparam int QS = XW + 6;
   localparam longint QM = ((longint'(1) << QS) + longint'(ALIGN_BYTES) - 1) /
                           longint'(ALIGN_BYTES);

   ffca_pkg::state_type state_ff, state_in;
   logic [16:0]         chunk_ff, chunk_in;
   logic [16:0]         size_ff, size_in;
   logic [15:0]         target_ff, target_in;
   logic [XW-1:0]       quot_ff, quot_in;
   logic [DW-1:0]       need_ff, need_in;
   logic                grown_ff, grown_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                found_ff, found_in;
   logic                big_ff, big_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [DW-1:0]       end_ff, end_in;
   logic [15:0]         res_addr_ff, res_addr_in;
   logic [1:0]          res_status_ff, res_status_in;
   ffca_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   ffca_pkg::op_type    op;
   logic [CW-1:0]       op_pos;
   logic [DW-1:0]       app_start;
   logic [DW-1:0]       app_len;

   logic [DW-1:0]       cell_start [MAX_BLOCKS];
   logic [DW-1:0]       cell_len   [MAX_BLOCKS];
   logic [MAX_BLOCKS:0] use_ext;
   ffca_pkg::cell_flag_type cell_flags [MAX_BLOCKS];

   logic                fit_any, match_any, first_big;
   logic [CW-1:0]       fit_pos, match_pos;
   logic [XW-1:0]       round_up;
   logic [XW+QS-1:0]    prod;
   logic [DW-1:0]       grow;
   logic [DW-1:0]       sel_addr;

   assign use_ext[MAX_BLOCKS] = 1'b0;

   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      logic [DW-1:0] p_start, p_len, n_start, n_len;
      logic          p_use, n_use;
      if (k == 0) begin : g_first
         assign p_start = '0;
         assign p_len   = '0;
         assign p_use   = 1'b0;
      end else begin : g_mid
         assign p_start = cell_start[k-1];
         assign p_len   = cell_len[k-1];
         assign p_use   = use_ext[k-1];
      end
      if (k == MAX_BLOCKS - 1) begin : g_last
         assign n_start = '0;
         assign n_len   = '0;
         assign n_use   = 1'b0;
      end else begin : g_inner
         assign n_start = cell_start[k+1];
         assign n_len   = cell_len[k+1];
         assign n_use   = use_ext[k+1];
      end
      ffca_cell #(
         .DW           (DW),
         .CW           (CW),
         .IDX          (k),
         .HEADER_BYTES (HEADER_BYTES),
         .ALIGN_BYTES  (ALIGN_BYTES)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .op_pos     (op_pos),
         .count      (count_ff),
         .need       (need_ff),
         .target     (target_ff),
         .app_start  (app_start),
         .app_len    (app_len),
         .prev_start (p_start),
         .prev_len   (p_len),
         .prev_use   (p_use),
         .next_start (n_start),
         .next_len   (n_len),
         .next_use   (n_use),
         .start      (cell_start[k]),
         .len        (cell_len[k]),
         .use_flag   (use_ext[k]),
         .flags      (cell_flags[k])
      );
   end

   always_comb begin
      fit_any   = 1'b0;
      match_any = 1'b0;
      first_big = 1'b0;
      fit_pos   = '0;
      match_pos = '0;
      for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
         if (cell_flags[k].fit) begin
            fit_any   = 1'b1;
            fit_pos   = CW'(k);
            first_big = cell_flags[k].big;
         end
         if (cell_flags[k].match) begin
            match_any = 1'b1;
            match_pos = CW'(k);
         end
      end
   end

   assign round_up = XW'(size_ff) + XW'(ALIGN_BYTES - 1);
   assign prod     = (XW+QS)'(round_up) * (XW+QS)'(QM);
   assign grow     = (need_ff > DW'(chunk_ff)) ? need_ff : DW'(chunk_ff);
   assign sel_addr = cell_start[pos_ff[PW-1:0]] + DW'(HEADER_BYTES);

   always_comb begin
      state_in      = state_ff;
      chunk_in      = csr_wr_en ? csr_wr_data : chunk_ff;
      size_in       = size_ff;
      target_in     = target_ff;
      quot_in       = quot_ff;
      need_in       = need_ff;
      grown_in      = grown_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      big_in        = big_ff;
      count_in      = count_ff;
      end_in        = end_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      op            = ffca_pkg::OP_NONE;
      op_pos        = pos_ff;
      app_start     = end_ff;
      app_len       = grow;
      req_stall     = 1'b1;
      case (state_ff)
         ffca_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               size_in     = req_payload.request_size;
               target_in   = req_payload.block_address;
               grown_in    = 1'b0;
               res_addr_in = '0;
               res_status_in = ffca_pkg::STATUS_OK;
               state_in    = (req_payload.command == ffca_pkg::CMD_FREE) ?
                             ffca_pkg::ST_FREE_FIND : ffca_pkg::ST_ALIGN;
            end
         end
         ffca_pkg::ST_ALIGN: begin
            quot_in  = prod[XW+QS-1:QS];
            state_in = ffca_pkg::ST_INIT;
         end
         ffca_pkg::ST_INIT: begin
            need_in = DW'(HEADER_BYTES) + DW'(quot_ff) * DW'(ALIGN_BYTES);
            if (end_ff == '0 && count_ff == '0 && chunk_ff != '0 &&
                DW'(chunk_ff) <= DW'(ARENA_BYTES)) begin
               op       = ffca_pkg::OP_APPEND;
               op_pos   = count_ff;
               app_len  = DW'(chunk_ff);
               end_in   = end_ff + DW'(chunk_ff);
               count_in = count_ff + CW'(1);
            end
            state_in = ffca_pkg::ST_SEARCH;
         end
         ffca_pkg::ST_SEARCH: begin
            found_in = fit_any;
            pos_in   = fit_pos;
            big_in   = first_big;
            state_in = ffca_pkg::ST_TAKE;
         end
         ffca_pkg::ST_TAKE: begin
            state_in = ffca_pkg::ST_DONE;
            if (found_ff) begin
               if (big_ff && count_ff >= CW'(MAX_BLOCKS)) begin
                  res_status_in = ffca_pkg::STATUS_TABLE_FULL;
               end else begin
                  op          = big_ff ? ffca_pkg::OP_SPLIT : ffca_pkg::OP_SET_USE;
                  res_addr_in = sel_addr[15:0];
                  if (big_ff) count_in = count_ff + CW'(1);
               end
            end else if (grown_ff ||
                         (end_ff + grow) > DW'(ARENA_BYTES)) begin
               res_status_in = ffca_pkg::STATUS_NO_MEMORY;
            end else if (count_ff >= CW'(MAX_BLOCKS)) begin
               res_status_in = ffca_pkg::STATUS_TABLE_FULL;
            end else begin
               op       = ffca_pkg::OP_APPEND;
               op_pos   = count_ff;
               end_in   = end_ff + grow;
               count_in = count_ff + CW'(1);
               grown_in = 1'b1;
               state_in = ffca_pkg::ST_SEARCH;
            end
         end
         ffca_pkg::ST_FREE_FIND: begin
            found_in = match_any;
            pos_in   = match_pos;
            state_in = ffca_pkg::ST_FREE_CLR;
         end
         ffca_pkg::ST_FREE_CLR: begin
            if (found_ff) begin
               op       = ffca_pkg::OP_CLR_USE;
               state_in = ffca_pkg::ST_FREE_NEXT;
            end else begin
               state_in = ffca_pkg::ST_DONE;
            end
         end
         ffca_pkg::ST_FREE_NEXT: begin
            if ((pos_ff + CW'(1)) < count_ff && !use_ext[pos_ff + CW'(1)]) begin
               op       = ffca_pkg::OP_MERGE;
               count_in = count_ff - CW'(1);
            end
            state_in = ffca_pkg::ST_FREE_PREV;
         end
         ffca_pkg::ST_FREE_PREV: begin
            if (pos_ff != '0 && !use_ext[pos_ff - CW'(1)]) begin
               op       = ffca_pkg::OP_MERGE;
               op_pos   = pos_ff - CW'(1);
               count_in = count_ff - CW'(1);
            end
            state_in = ffca_pkg::ST_DONE;
         end
         ffca_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.address = res_addr_ff;
               rsp_in.status  = res_status_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ffca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffca_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffca_pkg::ST_IDLE;
         chunk_ff     <= 17'd4096;
         count_ff     <= '0;
         end_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chunk_ff     <= chunk_in;
         count_ff     <= count_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      target_ff     <= target_in;
      quot_ff       <= quot_in;
      need_ff       <= need_in;
      grown_ff      <= grown_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      big_ff        <= big_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BLOCKS))
      else $error("Block table count exceeds its capacity.");

   a_end_bound: assert property (@(posedge clock) disable iff (reset)
      end_ff <= DW'(ARENA_BYTES))
      else $error("Committed region exceeds the arena.");

   a_done_posts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffca_pkg::ST_DONE && !rsp_valid_ff) |=>
      (rsp_valid_ff && state_ff == ffca_pkg::ST_IDLE))
      else $error("Finished command did not post its result.");

   a_grow_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffca_pkg::ST_TAKE && grown_ff) |-> found_ff)
      else $error("Grown block did not satisfy the allocation.");
`endif

endmodule

>>> tb/sv/tb_first_fit_coalescing_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_coalescing_allocator: testbench for the first-fit allocator
// A generator fills a queue of allocate and free commands, a bursty driver
// sends them, and an allocator model predicts each response at acceptance.
// A monitor with its own stall pattern compares responses in order.
// ----------------------------------------------------------------------------
module tb_first_fit_coalescing_allocator;

   localparam int ARENA  = 65536;
   localparam int ALIGN  = 8;
   localparam int HEADER = 24;
   localparam int BLOCKS = 64;
   localparam int LIMIT  = 600000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   ffca_pkg::req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   ffca_pkg::rsp_type rsp_payload;
   logic    csr_wr_en;
   logic [16:0] csr_wr_data;

   first_fit_coalescing_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Allocator model state.
   longint  blk_start [BLOCKS];
   longint  blk_len [BLOCKS];
   bit      blk_used [BLOCKS];
   int      blk_count;
   longint  arena_end;
   longint  grow_chunk;

   ffca_pkg::req_type pending_cmds [$];
   ffca_pkg::rsp_type expected_rsps [$];
   logic [15:0] live_addrs [$];
   int n_loaded, n_done, mismatches, cycles;
   int burst_left, gap_left, stall_left;

   function automatic void remove_block(int pos);
      for (int k = pos; k + 1 < blk_count; k++) begin
         blk_start[k] = blk_start[k+1];
         blk_len[k]   = blk_len[k+1];
         blk_used[k]  = blk_used[k+1];
      end
      blk_count--;
   endfunction

   function automatic void insert_block(int pos, longint start, longint len);
      for (int k = blk_count; k > pos; k--) begin
         blk_start[k] = blk_start[k-1];
         blk_len[k]   = blk_len[k-1];
         blk_used[k]  = blk_used[k-1];
      end
      blk_start[pos] = start;
      blk_len[pos]   = len;
      blk_used[pos]  = 1'b0;
      blk_count++;
   endfunction

   function automatic void extend_arena(longint bytes);
      insert_block(blk_count, arena_end, bytes);
      arena_end += bytes;
   endfunction

   function automatic ffca_pkg::status_type take_fit(longint need, ref longint where);
      for (int i = 0; i < blk_count; i++) begin
         if (!blk_used[i]) begin
            if (blk_len[i] >= need + HEADER + ALIGN) begin
               if (blk_count >= BLOCKS) return ffca_pkg::STATUS_TABLE_FULL;
               insert_block(i + 1, blk_start[i] + need, blk_len[i] - need);
               blk_len[i]  = need;
               blk_used[i] = 1'b1;
               where = blk_start[i] + HEADER;
               return ffca_pkg::STATUS_OK;
            end
            if (blk_len[i] >= need) begin
               blk_used[i] = 1'b1;
               where = blk_start[i] + HEADER;
               return ffca_pkg::STATUS_OK;
            end
         end
      end
      return ffca_pkg::STATUS_NO_MEMORY;
   endfunction

   function automatic ffca_pkg::rsp_type predict_allocator(ffca_pkg::req_type cmd);
      ffca_pkg::rsp_type    r;
      longint               where, asize, need, grow;
      ffca_pkg::status_type st;
      int                   i;
      where = 0;
      st = ffca_pkg::STATUS_OK;
      if (cmd.command == ffca_pkg::CMD_ALLOC) begin
         asize = ((longint'(cmd.request_size) + ALIGN - 1) / ALIGN) * ALIGN;
         need = HEADER + asize;
         if (arena_end == 0 && blk_count == 0 && grow_chunk > 0 && grow_chunk <= ARENA)
            extend_arena(grow_chunk);
         st = take_fit(need, where);
         if (st == ffca_pkg::STATUS_NO_MEMORY) begin
            grow = need > grow_chunk ? need : grow_chunk;
            if (arena_end + grow > ARENA) begin
               st = ffca_pkg::STATUS_NO_MEMORY;
            end else if (blk_count >= BLOCKS) begin
               st = ffca_pkg::STATUS_TABLE_FULL;
            end else begin
               extend_arena(grow);
               st = take_fit(need, where);
            end
         end
         if (st != ffca_pkg::STATUS_OK) where = 0;
         else live_addrs.push_back(where[15:0]);
      end else begin
         for (i = 0; i < blk_count; i++)
            if (blk_used[i] && blk_start[i] + HEADER == longint'(cmd.block_address)) break;
         if (i < blk_count) begin
            for (int k = 0; k < live_addrs.size(); k++)
               if (live_addrs[k] == cmd.block_address) begin
                  live_addrs.delete(k);
                  break;
               end
            blk_used[i] = 1'b0;
            if (i + 1 < blk_count && !blk_used[i+1]) begin
               blk_len[i] += blk_len[i+1];
               remove_block(i + 1);
            end
            if (i > 0 && !blk_used[i-1]) begin
               blk_len[i-1] += blk_len[i];
               remove_block(i);
            end
         end
      end
      r.address = where[15:0];
      r.status  = st;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Driver: bursts of transfers separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) expected_rsps.push_back(predict_allocator(req_payload));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               req_payload <= pending_cmds.pop_front();
               req_valid   <= 1'b1;
               n_loaded++;
               if (burst_left == 0) burst_left = $urandom_range(1, 10);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls in runs of its own and checks every response transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_done++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected response: address %0d status %0d",
                           rsp_payload.address, rsp_payload.status);
            end else begin
               ffca_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (e.address !== rsp_payload.address || e.status !== rsp_payload.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected address %0d status %0d, got %0d %0d",
                              e.address, e.status, rsp_payload.address, rsp_payload.status);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 40);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_cmd(ffca_pkg::command_type c, int size, int addr);
      ffca_pkg::req_type r;
      while (pending_cmds.size() > 1) @(posedge clock);
      r.command       = c;
      r.request_size  = size[16:0];
      r.block_address = addr[15:0];
      pending_cmds.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || n_loaded != n_done) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_chunk(int value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[16:0];
      grow_chunk  = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_cmds(int count);
      int sel, size;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 55 || live_addrs.size() == 0) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) size = $urandom_range(0, 256);
            else if (sel < 95) size = $urandom_range(0, 4096);
            else if (sel < 98) size = $urandom_range(0, 131071);
            else size = 65536;
            queue_cmd(ffca_pkg::CMD_ALLOC, size, $urandom_range(0, 65535));
         end else if (sel < 95) begin
            queue_cmd(ffca_pkg::CMD_FREE, $urandom_range(0, 131071),
                      live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
         end else begin
            queue_cmd(ffca_pkg::CMD_FREE, $urandom_range(0, 131071),
                      $urandom_range(0, 65535));
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      blk_count   = 0;
      arena_end   = 0;
      grow_chunk  = 4096;
      n_loaded = 0; n_done = 0; mismatches = 0; cycles = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: first commit, rounding, splits, merges, bad frees, no memory.
      queue_cmd(ffca_pkg::CMD_ALLOC, 0, 0);
      queue_cmd(ffca_pkg::CMD_ALLOC, 1, 16'hFFFF);
      queue_cmd(ffca_pkg::CMD_ALLOC, 8, 0);
      queue_cmd(ffca_pkg::CMD_ALLOC, 9, 0);
      queue_cmd(ffca_pkg::CMD_FREE, 0, 56);
      queue_cmd(ffca_pkg::CMD_FREE, 0, 56);
      queue_cmd(ffca_pkg::CMD_FREE, 0, 0);
      queue_cmd(ffca_pkg::CMD_FREE, 131071, 16'hFFFF);
      queue_cmd(ffca_pkg::CMD_FREE, 0, 24);
      queue_cmd(ffca_pkg::CMD_FREE, 0, 112);
      queue_cmd(ffca_pkg::CMD_ALLOC, 65536, 0);
      queue_cmd(ffca_pkg::CMD_ALLOC, 131071, 0);
      queue_cmd(ffca_pkg::CMD_ALLOC, 4000, 0);
      queue_cmd(ffca_pkg::CMD_ALLOC, 60000, 0);
      queue_cmd(ffca_pkg::CMD_FREE, 0, 88);

      // Small chunk: tiny blocks fill the table.
      write_chunk(8);
      for (int n = 0; n < 70; n++) queue_cmd(ffca_pkg::CMD_ALLOC, 0, 0);
      random_cmds(150);
      write_chunk(65536);
      random_cmds(200);
      write_chunk($urandom_range(8, 65536));
      random_cmds(200);
      write_chunk(24);
      random_cmds(200);
      write_chunk(4096);
      random_cmds(200);

      wait_drained();
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
